>>> hw/rtl/led_pkg.sv
package led_pkg;

    localparam int TableDepth   = 32;
    localparam int CylBits      = 10;
    localparam int IdxBits      = $clog2(TableDepth);
    localparam int TotBits      = 32;
    localparam int QueueDepth   = 2;

    localparam logic        ActAdd   = 1'b0;
    localparam logic        ActServe = 1'b1;

    localparam logic [1:0]  StatOk    = 2'd0;
    localparam logic [1:0]  StatEmpty = 2'd1;
    localparam logic [1:0]  StatFull  = 2'd2;

    localparam logic [1:0]  RegStartCyl = 2'd0;

    typedef struct packed {
        logic               action;
        logic [CylBits-1:0] cylinder;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [CylBits-1:0] served_cylinder;
        logic [CylBits-1:0] distance;
        logic [TotBits-1:0] wait_time;
        logic [TotBits-1:0] total_distance;
        logic               turned;
        logic               moving_up;
    } t_res;

endpackage

>>> hw/rtl/led_front.sv
module led_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic          i_action,
    input  logic [9:0]    i_cylinder,
    output logic          o_cmd_valid,
    output led_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);
    import led_pkg::*;

    localparam int PtrBits = $clog2(QueueDepth);

    t_cmd                r_q [QueueDepth];
    logic [PtrBits-1:0]  r_wp, r_rp;
    logic [PtrBits:0]    r_cnt;
    logic                w_push, w_pop;

    assign o_full      = (r_cnt == (PtrBits+1)'(QueueDepth));
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= '{action: i_action, cylinder: i_cylinder[CylBits-1:0]};
                r_wp      <= r_wp + 1'b1;
            end
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrBits+1)'(w_push) - (PtrBits+1)'(w_pop);
        end
    end
endmodule

>>> hw/rtl/led_back.sv
module led_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  led_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    input  logic          i_cfg_we,
    input  logic [9:0]    i_cfg_start,
    output logic [9:0]    o_start,
    output logic          o_res_valid,
    output led_pkg::t_res o_res,
    input  logic          i_res_take
);
    import led_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DONE, S_OUT} t_state;

    t_state              r_state;
    logic [TableDepth-1:0] r_valid;
    logic [CylBits-1:0]  r_cyl   [TableDepth];
    logic [TotBits-1:0]  r_stamp [TableDepth];
    logic [CylBits-1:0]  r_head, r_start;
    logic                r_up, r_turned, r_pass2, r_found;
    logic [TotBits-1:0]  r_total;
    logic [IdxBits:0]    r_i;
    logic [IdxBits-1:0]  r_best;
    logic [CylBits-1:0]  r_gap;
    t_res                r_res;

    logic [IdxBits-1:0]  w_idx;
    logic [CylBits-1:0]  w_c, w_gap, w_pc;
    logic                w_side, w_free, w_hit;
    logic [IdxBits-1:0]  w_free_idx;
    logic [TotBits:0]    w_sum;
    logic [TotBits-1:0]  w_tot, w_st;

    assign w_idx = r_i[IdxBits-1:0];
    assign w_c   = r_cyl[w_idx];
    assign w_side = r_up ? (w_c >= r_head) : (w_c <= r_head);
    assign w_gap = r_up ? (w_c - r_head) : (r_head - w_c);
    assign w_hit = r_valid[w_idx] && w_side && (!r_found || w_gap < r_gap);

    // lowest free slot, priority encoder
    always_comb begin
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int k = TableDepth-1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                w_free     = 1'b1;
                w_free_idx = IdxBits'(k);
            end
        end
    end

    assign w_pc  = r_cyl[r_best];
    assign w_st  = r_stamp[r_best];
    assign w_sum = {1'b0, r_total} + {{(TotBits+1-CylBits){1'b0}}, r_gap};
    assign w_tot = w_sum[TotBits] ? '1 : w_sum[TotBits-1:0];

    assign o_cmd_take  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;
    assign o_start     = r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_head  <= '0;
            r_start <= '0;
            r_up    <= 1'b1;
            r_total <= '0;
        end else begin
            if (i_cfg_we) begin
                r_start <= i_cfg_start;
                r_head  <= i_cfg_start;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.action == ActAdd) begin
                            r_res <= '{status: (w_free ? StatOk : StatFull),
                                       served_cylinder: {CylBits{1'b0}},
                                       distance: {CylBits{1'b0}},
                                       wait_time: {TotBits{1'b0}},
                                       total_distance: r_total,
                                       turned: 1'b0,
                                       moving_up: r_up};
                            if (w_free) begin
                                r_valid[w_free_idx] <= 1'b1;
                                r_cyl[w_free_idx]   <= i_cmd.cylinder;
                                r_stamp[w_free_idx] <= r_total;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_i      <= '0;
                            r_found  <= 1'b0;
                            r_pass2  <= 1'b0;
                            r_turned <= 1'b0;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_best  <= w_idx;
                        r_gap   <= w_gap;
                    end
                    if (r_i == (IdxBits+1)'(TableDepth-1)) r_state <= S_DONE;
                    r_i <= r_i + 1'b1;
                end
                S_DONE: begin
                    if (r_found) begin
                        r_total <= w_tot;
                        r_head  <= w_pc;
                        r_valid[r_best] <= 1'b0;
                        r_res <= '{status: StatOk,
                                   served_cylinder: w_pc,
                                   distance: r_gap,
                                   wait_time: ((w_tot >= w_st) ? (w_tot - w_st)
                                                               : {TotBits{1'b0}}),
                                   total_distance: w_tot,
                                   turned: r_turned,
                                   moving_up: r_up};
                        r_state <= S_OUT;
                    end else if (!r_pass2 && (r_valid != '0)) begin
                        r_up     <= !r_up;
                        r_turned <= 1'b1;
                        r_pass2  <= 1'b1;
                        r_i      <= '0;
                        r_state  <= S_SCAN;
                    end else begin
                        r_res <= '{status: StatEmpty,
                                   served_cylinder: {CylBits{1'b0}},
                                   distance: {CylBits{1'b0}},
                                   wait_time: {TotBits{1'b0}},
                                   total_distance: r_total,
                                   turned: 1'b0,
                                   moving_up: r_up};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_res_take) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/look_elevator_disk_scheduler.sv
// add: queue entry, then result register; serve: one scan of 32 entries with a
// single comparator plus a decide step; a turn adds a second scan and decide
// throughput: one item at a time in the back end; a 2-entry command queue in front
// keeps taking pushes, until it fills, while a serve scans or a result waits
// reset: synchronous active low; table empty, head at 0, moving up, total 0
module look_elevator_disk_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input queue side
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [9:0]  i_cylinder,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [9:0]  o_served_cylinder,
    output logic [9:0]  o_distance,
    output logic [31:0] o_wait_time,
    output logic [31:0] o_total_distance,
    output logic        o_turned,
    output logic        o_moving_up,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import led_pkg::*;

    logic  w_cmd_valid, w_cmd_take, w_res_valid, w_cfg_we;
    t_cmd  w_cmd;
    t_res  w_res;
    logic [9:0] w_start;

    // only register 0 exists, at byte address 0
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr == RegStartCyl);
    assign prdata   = (paddr == RegStartCyl) ? {22'd0, w_start} : 32'd0;

    // front: command queue
    led_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_action    (i_action),
        .i_cylinder  (i_cylinder),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    // back: table, scan and result register
    led_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_start (pwdata[9:0]),
        .o_start     (w_start),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (pop)
    );

    assign empty             = !w_res_valid;
    assign o_status          = w_res.status;
    assign o_served_cylinder = w_res.served_cylinder;
    assign o_distance        = w_res.distance;
    assign o_wait_time       = w_res.wait_time;
    assign o_total_distance  = w_res.total_distance;
    assign o_turned          = w_res.turned;
    assign o_moving_up       = w_res.moving_up;
endmodule

>>> verif/tb_look_elevator_disk_scheduler.sv
`timescale 1ns / 100ps

module tb_look_elevator_disk_scheduler;
    import led_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_action;
    logic [9:0]  i_cylinder;
    logic        empty;
    logic        pop;
    logic [1:0]  o_status;
    logic [9:0]  o_served_cylinder;
    logic [9:0]  o_distance;
    logic [31:0] o_wait_time;
    logic [31:0] o_total_distance;
    logic        o_turned;
    logic        o_moving_up;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    look_elevator_disk_scheduler i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_cylinder       (i_cylinder),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_served_cylinder(o_served_cylinder),
        .o_distance       (o_distance),
        .o_wait_time      (o_wait_time),
        .o_total_distance (o_total_distance),
        .o_turned         (o_turned),
        .o_moving_up      (o_moving_up),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // clock: 10 ns period
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler mirror: pending table, head, direction, travelled total
    bit          pend_valid [TableDepth];
    logic [9:0]  pend_cyl   [TableDepth];
    logic [31:0] pend_stamp [TableDepth];
    logic [9:0]  head_cyl;
    bit          heading_up;
    logic [31:0] travel_sum;

    t_res served_q[$];     // results still owed by the block
    int   mismatches;
    int   n_items;
    int   n_results;
    int   n_full;
    int   n_empty;
    int   n_turns;
    bit   calm;            // no idling on either side
    bit   squeeze_req;     // ask the result side for one long hold-off

    // nearest pending entry on one side of the head, head included; lowest index on ties
    function automatic int nearest_pending(bit up);
        int          best;
        logic [9:0]  best_gap;
        logic [9:0]  gap;
        best = -1;
        best_gap = '0;
        for (int i = 0; i < TableDepth; i++) begin
            if (!pend_valid[i]) continue;
            if (up) begin
                if (pend_cyl[i] < head_cyl) continue;
                gap = pend_cyl[i] - head_cyl;
            end else begin
                if (pend_cyl[i] > head_cyl) continue;
                gap = head_cyl - pend_cyl[i];
            end
            if (best < 0 || gap < best_gap) begin
                best = i;
                best_gap = gap;
            end
        end
        return best;
    endfunction

    function automatic int pending_count();
        int n;
        n = 0;
        for (int i = 0; i < TableDepth; i++) n += int'(pend_valid[i]);
        return n;
    endfunction

    // advance the mirror by one item and return the result it owes
    function automatic t_res schedule_step(logic act, logic [9:0] cyl);
        t_res r;
        int   slot;
        int   pick;
        r = '0;
        if (act == ActAdd) begin
            slot = -1;
            for (int i = 0; i < TableDepth; i++)
                if (!pend_valid[i] && slot < 0) slot = i;
            if (slot < 0) begin
                r.status = StatFull;
            end else begin
                pend_valid[slot] = 1'b1;
                pend_cyl[slot]   = cyl;
                pend_stamp[slot] = travel_sum;
                r.status = StatOk;
            end
        end else begin
            pick = nearest_pending(heading_up);
            // nothing ahead: reverse, but only if anything is pending at all
            if (pick < 0 && pending_count() > 0) begin
                heading_up = !heading_up;
                r.turned = 1'b1;
                pick = nearest_pending(heading_up);
            end
            if (pick < 0) begin
                r.status = StatEmpty;
                r.turned = 1'b0;
            end else begin
                r.status = StatOk;
                r.distance = (pend_cyl[pick] >= head_cyl) ? pend_cyl[pick] - head_cyl
                                                          : head_cyl - pend_cyl[pick];
                // saturating total
                if (travel_sum > 32'hFFFF_FFFF - r.distance) travel_sum = 32'hFFFF_FFFF;
                else travel_sum = travel_sum + r.distance;
                r.wait_time = (travel_sum >= pend_stamp[pick]) ? travel_sum - pend_stamp[pick]
                                                               : '0;
                r.served_cylinder = pend_cyl[pick];
                head_cyl = pend_cyl[pick];
                pend_valid[pick] = 1'b0;
            end
        end
        r.total_distance = travel_sum;
        r.moving_up = heading_up;
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d (result %0d)",
                     what, exp_v, got_v, n_results);
    endtask

    // ---------------- item side ----------------
    // push stays high from item to item unless an idle burst drops it
    task automatic send_item(logic act, logic [9:0] cyl, output t_res owed);
        int gap;
        i_action   <= act;
        i_cylinder <= cyl;
        push       <= 1'b1;
        do @(posedge i_clk); while (full);
        owed = schedule_step(act, cyl);
        served_q.insert(served_q.size(), owed);
        n_items++;
        if (owed.status == StatFull) n_full++;
        if (owed.status == StatEmpty) n_empty++;
        if (owed.turned) n_turns++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register write while idle, then read back
    task automatic set_start_cylinder(logic [9:0] v);
        push <= 1'b0;
        wait (served_q.size() == 0);
        // settling margin; every owed result is already taken, so no serve is still scanning
        repeat (80) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RegStartCyl;
        pwdata  <= {22'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        head_cyl = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {22'b0, v})
            note_mismatch("start_cylinder readback", 32'(v), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // random cylinder: mostly uniform, some extremes and some near the head
    function automatic logic [9:0] pick_cylinder();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 10'd0;
        if (k == 1) return 10'd1023;
        if (k == 2) return head_cyl + 10'($urandom_range(0, 4)) - 10'd2;
        return 10'($urandom_range(0, 1023));
    endfunction

    // random phase: occupancy-steered add/serve mix, with fill and drain runs
    task automatic random_phase(int count);
        t_res owed;
        int   n;
        int   p_add;
        logic act;
        for (int k = 0; k < count; k++) begin
            n = pending_count();
            if (n < 4) p_add = 75;
            else if (n > 28) p_add = 30;
            else p_add = 50;
            // now and then run into a full table or an empty one
            if ($urandom_range(0, 99) < 3) begin
                act = 1'($urandom_range(0, 1));
                repeat ($urandom_range(6, 20)) begin
                    send_item(act, pick_cylinder(), owed);
                    k++;
                end
            end else begin
                act = ($urandom_range(0, 99) < p_add) ? ActAdd : ActServe;
                send_item(act, pick_cylinder(), owed);
            end
        end
    endtask

    // ---------------- result side ----------------
    initial begin : result_side
        int   hold;
        t_res want;
        hold = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                n_results++;
                if (served_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result with nothing owed");
                end else begin
                    want = served_q.pop_front();
                    if (o_status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(o_status));
                    if (o_served_cylinder !== want.served_cylinder)
                        note_mismatch("served_cylinder", 32'(want.served_cylinder),
                                      32'(o_served_cylinder));
                    if (o_distance !== want.distance)
                        note_mismatch("distance", 32'(want.distance), 32'(o_distance));
                    if (o_wait_time !== want.wait_time)
                        note_mismatch("wait_time", want.wait_time, o_wait_time);
                    if (o_total_distance !== want.total_distance)
                        note_mismatch("total_distance", want.total_distance,
                                      o_total_distance);
                    if (o_turned !== want.turned)
                        note_mismatch("turned", 32'(want.turned), 32'(o_turned));
                    if (o_moving_up !== want.moving_up)
                        note_mismatch("moving_up", 32'(want.moving_up), 32'(o_moving_up));
                end
            end
            // one long stall so the command queue backs up against full
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold = 400;
            end else if (hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 9);
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ---------------- directed table ----------------
    typedef struct {
        logic       act;
        logic [9:0] cyl;
        int         reps;     // repeat count
        bit         rnd;      // random cylinder per repeat
        bit         typed;    // hand-written expectation below
        logic [1:0] st;
        logic [9:0] srv;
        logic [9:0] dst;
        bit         trn;
    } t_row;

    t_row plan [] = '{
        // serve with nothing pending
        '{ActServe, 10'd0,    1,  0, 1, StatEmpty, 10'd0,    10'd0,    0},
        '{ActAdd,   10'd1023, 1,  0, 1, StatOk,    10'd0,    10'd0,    0},
        '{ActAdd,   10'd0,    1,  0, 1, StatOk,    10'd0,    10'd0,    0},
        // request sitting at the head
        '{ActServe, 10'd0,    1,  0, 1, StatOk,    10'd0,    10'd0,    0},
        // full stroke
        '{ActServe, 10'd0,    1,  0, 1, StatOk,    10'd1023, 10'd1023, 0},
        // duplicate cylinders, then one at the head
        '{ActAdd,   10'd500,  2,  0, 1, StatOk,    10'd0,    10'd0,    0},
        '{ActAdd,   10'd1023, 1,  0, 1, StatOk,    10'd0,    10'd0,    0},
        '{ActServe, 10'd0,    1,  0, 1, StatOk,    10'd1023, 10'd0,    0},
        // nothing above: reverse
        '{ActServe, 10'd0,    1,  0, 1, StatOk,    10'd500,  10'd523,  1},
        '{ActServe, 10'd0,    1,  0, 1, StatOk,    10'd500,  10'd0,    0},
        '{ActServe, 10'd0,    1,  0, 1, StatEmpty, 10'd0,    10'd0,    0},
        // fill the table, then one too many
        '{ActAdd,   10'd0,    32, 1, 0, StatOk,    10'd0,    10'd0,    0},
        '{ActAdd,   10'd7,    1,  0, 1, StatFull,  10'd0,    10'd0,    0},
        '{ActServe, 10'd0,    32, 0, 0, StatOk,    10'd0,    10'd0,    0},
        '{ActServe, 10'd0,    1,  0, 1, StatEmpty, 10'd0,    10'd0,    0}
    };

    // ---------------- main sequence ----------------
    initial begin : stimulus
        t_res owed;
        logic [9:0] c;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_action = ActAdd;
        i_cylinder = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = RegStartCyl;
        pwdata = '0;
        mismatches = 0;
        n_items = 0;
        n_results = 0;
        n_full = 0;
        n_empty = 0;
        n_turns = 0;
        calm = 1'b0;
        squeeze_req = 1'b0;
        for (int i = 0; i < TableDepth; i++) pend_valid[i] = 1'b0;
        head_cyl = '0;
        heading_up = 1'b1;
        travel_sum = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, starting from the reset state
        foreach (plan[r]) begin
            for (int k = 0; k < plan[r].reps; k++) begin
                c = plan[r].rnd ? 10'($urandom_range(0, 1023)) : plan[r].cyl;
                send_item(plan[r].act, c, owed);
                if (plan[r].typed && (owed.status !== plan[r].st ||
                    owed.served_cylinder !== plan[r].srv ||
                    owed.distance !== plan[r].dst || owed.turned !== plan[r].trn))
                    note_mismatch("directed row", 32'(r), 32'(owed.status));
            end
        end

        // random phases at different start positions, extremes included
        set_start_cylinder(10'd1023);
        squeeze_req = 1'b1;
        random_phase(280);
        set_start_cylinder(10'd0);
        random_phase(280);
        set_start_cylinder(10'd512 + 10'($urandom_range(0, 511)));
        random_phase(280);
        set_start_cylinder(10'($urandom_range(0, 1023)));
        calm = 1'b1;
        random_phase(260);
        push <= 1'b0;

        wait (served_q.size() == 0);
        repeat (80) @(posedge i_clk);
        if (served_q.size() != 0) mismatches++;
        $display("covered %0d items and %0d results: %0d full, %0d empty, %0d turns",
                 n_items, n_results, n_full, n_empty, n_turns);
        $display("start cylinder set at 0, 1023 and two random points; one long result stall");
        if (mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
